[rtl/cvsl_pkg.sv]
package cvsl_pkg;

  // Fixed sizes of the line window and the job queue.
  localparam int unsigned WIN_LINES = 8;
  localparam int unsigned QDEPTH    = 4;
  localparam int unsigned DEF_MAX_WIDTH = 1024;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_VERT_SHIFT = 2'd0;
  localparam logic [1:0] REG_LOW_PASS   = 2'd1;
  localparam logic [1:0] REG_WIDTH      = 2'd2;
  localparam logic [1:0] REG_HEIGHT     = 2'd3;

  typedef struct packed {
    logic [7:0] luma_in;
    logic [7:0] chroma_in;
    logic       frame_start;
  } in_item_t;

  typedef struct packed {
    logic [7:0] luma_out;
    logic [7:0] chroma_out;
    logic [9:0] out_row;
    logic       run_last;
  } out_item_t;

  // Decoded settings shared by the front and back parts.
  typedef struct packed {
    logic        pos;
    logic        neg;
    logic [2:0]  d;
    logic [2:0]  f;
    logic        lp;
    logic [10:0] h;
    logic [2:0]  look;
  } cfg_t;

  // One word column of the window plus the range of rows to emit.
  typedef struct packed {
    logic [WIN_LINES-1:0][15:0] words;
    logic [9:0]                 row_first;
    logic [9:0]                 row_last;
  } job_t;

endpackage

[rtl/cvsl_front.sv]
module cvsl_front #(
  parameter int unsigned MAX_WIDTH = cvsl_pkg::DEF_MAX_WIDTH,
  localparam int unsigned CW = $clog2(MAX_WIDTH),
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cvsl_pkg::cfg_t     cfg_i,
  input  logic [WW-1:0]      width_i,
  input  logic               in_valid_i,
  input  cvsl_pkg::in_item_t in_data_i,
  output logic               in_stall_o,
  input  logic [2:0]         q_count_i,
  output logic               push_o,
  output cvsl_pkg::job_t     job_o
);
  import cvsl_pkg::*;

  logic [15:0] mem [WIN_LINES][MAX_WIDTH];
  logic [WIN_LINES-1:0][15:0] rd_q;
  logic [CW-1:0] col_q, col_d, c0;
  logic [9:0]  row_q, row_d, row;
  logic [10:0] r0, rn;
  logic [WW:0] cn;
  logic        accept, emit;
  logic        f1_valid_q;
  logic [2:0]  wslot_q;
  logic [15:0] wword_q;
  logic [9:0]  first_q, last_q, first_d, last_d;

  // Queue room counts the beat still in the read stage.
  assign in_stall_o = ({1'b0, q_count_i} + {3'b0, f1_valid_q}) >= 4'(QDEPTH);
  assign accept     = in_valid_i && !in_stall_o;

  // Position of the word and the rows it releases.
  always_comb begin
    c0 = in_data_i.frame_start ? '0 : col_q;
    r0 = in_data_i.frame_start ? '0 : {1'b0, row_q};
    if ({1'b0, c0} >= width_i) begin
      c0 = '0;
      r0 = r0 + 11'd1;
    end
    if (r0 >= cfg_i.h) r0 = '0;
    row = r0[9:0];
    emit    = 1'b0;
    first_d = '0;
    last_d  = row;
    if (r0 == cfg_i.h - 11'd1) begin
      emit    = 1'b1;
      first_d = (row >= {7'b0, cfg_i.look}) ? row - {7'b0, cfg_i.look} : '0;
    end else if (row >= {7'b0, cfg_i.look}) begin
      emit    = 1'b1;
      first_d = row - {7'b0, cfg_i.look};
      last_d  = first_d;
    end
    cn    = {1'b0, c0} + 1'b1;
    col_d = cn[CW-1:0];
    row_d = row;
    if (cn >= {1'b0, width_i}) begin
      col_d = '0;
      rn    = r0 + 11'd1;
      row_d = (rn >= cfg_i.h) ? '0 : rn[9:0];
    end else begin
      rn = r0;
    end
  end

  // Counters and the read stage control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      f1_valid_q <= 1'b0;
    end else begin
      f1_valid_q <= accept && emit;
      if (accept) begin
        col_q <= col_d;
        row_q <= row_d;
      end
    end
  end

  // Line banks: one write, and every bank read at the same column.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mem[row[2:0]][c0] <= {in_data_i.chroma_in, in_data_i.luma_in};
      for (int i = 0; i < WIN_LINES; i++) rd_q[i] <= mem[i][c0];
      wslot_q <= row[2:0];
      wword_q <= {in_data_i.chroma_in, in_data_i.luma_in};
      first_q <= first_d;
      last_q  <= last_d;
    end
  end

  // The bank being written reads back the new word.
  always_comb begin
    for (int i = 0; i < WIN_LINES; i++) begin
      job_o.words[i] = (3'(i) == wslot_q) ? wword_q : rd_q[i];
    end
    job_o.row_first = first_q;
    job_o.row_last  = last_q;
  end
  assign push_o = f1_valid_q;

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> first_q <= last_q) else $error("row range inverted");
  a_lag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> $past(accept)) else $error("job without a beat");
  a_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> q_count_i < 3'(QDEPTH)) else $error("queue has no room");

endmodule

[rtl/cvsl_queue.sv]
module cvsl_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  cvsl_pkg::job_t job_i,
  input  logic           pop_i,
  output cvsl_pkg::job_t head_o,
  output logic           empty_o,
  output logic [2:0]     count_o
);
  import cvsl_pkg::*;

  localparam int unsigned PW = $clog2(QDEPTH);

  job_t          slots_q [QDEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [2:0]    cnt_q;

  assign head_o  = slots_q[rd_q];
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + {2'b0, push_i} - {2'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) slots_q[wr_q] <= job_i;
  end

  a_over: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (cnt_q != 3'(QDEPTH)) || pop_i) else $error("queue overflow");
  a_under: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("queue underflow");

endmodule

[rtl/cvsl_back.sv]
module cvsl_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cvsl_pkg::cfg_t      cfg_i,
  input  cvsl_pkg::job_t      head_i,
  input  logic                empty_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output cvsl_pkg::out_item_t out_data_o
);
  import cvsl_pkg::*;

  logic [9:0]  k_q, k_cur;
  logic        started_q, fire;
  logic [7:0][7:0] ch;
  logic [10:0] kx;
  logic [7:0]  sa, sb, sc, res;
  logic [9:0]  sum;
  logic        out_valid_q;
  out_item_t   out_q, out_d;

  // Vertical interpolation of one row from the column of chroma bytes.
  function automatic logic [7:0] shift_at(input logic [7:0][7:0] c,
                                          input logic [10:0] k, input cfg_t cf);
    logic [2:0]  ia, ib;
    logic [3:0]  wa, wb;
    logic [11:0] acc;
    logic [7:0]  r;
    r = c[k[2:0]];
    if (cf.pos && (k + {8'b0, cf.d} + 11'd1 < cf.h)) begin
      ia  = k[2:0] + cf.d;
      ib  = ia + 3'd1;
      wa  = 4'd8 - {1'b0, cf.f};
      wb  = {1'b0, cf.f};
      acc = {4'b0, c[ia]} * {8'b0, wa} + {4'b0, c[ib]} * {8'b0, wb};
      r   = acc[10:3];
    end else if (cf.neg && (k > {8'b0, cf.d})) begin
      ib  = k[2:0] - cf.d;
      ia  = ib - 3'd1;
      wa  = {1'b0, cf.f};
      wb  = 4'd8 - {1'b0, cf.f};
      acc = {4'b0, c[ia]} * {8'b0, wa} + {4'b0, c[ib]} * {8'b0, wb};
      r   = acc[10:3];
    end
    return r;
  endfunction

  assign fire  = !empty_i && (!out_valid_q || !out_stall_i);
  assign k_cur = started_q ? k_q : head_i.row_first;
  assign pop_o = fire && (k_cur == head_i.row_last);

  // Shift, then the optional 1-2-1 filter across three shifted rows.
  always_comb begin
    for (int i = 0; i < WIN_LINES; i++) ch[i] = head_i.words[i][15:8];
    kx  = {1'b0, k_cur};
    sa  = shift_at(ch, kx - 11'd1, cfg_i);
    sb  = shift_at(ch, kx, cfg_i);
    sc  = shift_at(ch, kx + 11'd1, cfg_i);
    sum = {2'b0, sa} + {1'b0, sb, 1'b0} + {2'b0, sc};
    res = (cfg_i.lp && (kx >= 11'd1) && (kx <= cfg_i.h - 11'd2)) ? sum[9:2] : sb;
    out_d.luma_out   = head_i.words[k_cur[2:0]][7:0];
    out_d.chroma_out = res;
    out_d.out_row    = k_cur;
    out_d.run_last   = (k_cur == head_i.row_last);
  end

  // Row walk over the head job and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q   <= 1'b0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        started_q <= !pop_o;
        k_q       <= k_cur + 10'd1;
      end
      if (!out_valid_q || !out_stall_i) out_valid_q <= fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |-> k_cur <= head_i.row_last) else $error("row walk past range");

endmodule

[rtl/chroma_vertical_shift_lowpass.sv]
// A beat passes the front read stage, a queue slot and then the output register.
// Throughput: one input beat per cycle while the queue has room; a beat that
// releases n rows sends them one per cycle from the row walk unless stalled.
// Reset: counters, queue and register values return to their defaults at once;
// the line banks are not cleared and hold no valid data until written.
module chroma_vertical_shift_lowpass #(
  parameter int unsigned MAX_WIDTH = cvsl_pkg::DEF_MAX_WIDTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  cvsl_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output cvsl_pkg::out_item_t out_data_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import cvsl_pkg::*;

  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);

  logic [6:0]  vshift_q;
  logic        lp_q;
  logic [10:0] fw_q, fh_q;
  cfg_t        cfg;
  logic [WW-1:0] width;
  logic [5:0]  mag;
  logic        push, pop, empty;
  logic [2:0]  count;
  job_t        job, head;

  assign pready = 1'b1;

  // Register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vshift_q <= '0;
      lp_q     <= 1'b0;
      fw_q     <= 11'd720;
      fh_q     <= 11'd480;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_VERT_SHIFT: vshift_q <= pwdata[6:0];
        REG_LOW_PASS:   lp_q     <= pwdata[0];
        REG_WIDTH:      fw_q     <= pwdata[10:0];
        REG_HEIGHT:     fh_q     <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  // Register reads.
  always_comb begin
    unique case (paddr[3:2])
      REG_VERT_SHIFT: prdata = {25'b0, vshift_q};
      REG_LOW_PASS:   prdata = {31'b0, lp_q};
      REG_WIDTH:      prdata = {21'b0, fw_q};
      REG_HEIGHT:     prdata = {21'b0, fh_q};
      default:        prdata = '0;
    endcase
  end

  // Clamp the settings and split the shift into lines and eighths.
  always_comb begin
    if (!vshift_q[6] && vshift_q > 7'd32)      mag = 6'd32;
    else if (!vshift_q[6])                     mag = vshift_q[5:0];
    else if (vshift_q < 7'h60)                 mag = 6'd32;
    else                                       mag = 6'(7'd0 - vshift_q);
    cfg.pos  = !vshift_q[6] && (vshift_q != 7'd0);
    cfg.neg  = vshift_q[6];
    cfg.d    = mag[5:3];
    cfg.f    = mag[2:0];
    cfg.lp   = lp_q;
    cfg.h    = (fh_q < 11'd3) ? 11'd3 : ((fh_q > 11'd1024) ? 11'd1024 : fh_q);
    cfg.look = (cfg.pos ? cfg.d + 3'd1 : 3'd0) + {2'b0, lp_q};
    if ({{(WW + 1){1'b0}}, fw_q} < (WW + 12)'(4))
      width = WW'(4);
    else if ({{(WW + 1){1'b0}}, fw_q} > (WW + 12)'(MAX_WIDTH))
      width = WW'(MAX_WIDTH);
    else
      width = WW'(fw_q);
  end

  cvsl_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk_i, .rst_ni, .cfg_i(cfg), .width_i(width), .in_valid_i, .in_data_i,
    .in_stall_o, .q_count_i(count), .push_o(push), .job_o(job)
  );

  cvsl_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .job_i(job), .pop_i(pop), .head_o(head),
    .empty_o(empty), .count_o(count)
  );

  cvsl_back u_back (
    .clk_i, .rst_ni, .cfg_i(cfg), .head_i(head), .empty_i(empty), .pop_o(pop),
    .out_valid_o, .out_stall_i, .out_data_o
  );

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import cvsl_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 3000000;
  localparam int unsigned DRAIN_CYCLES = 20;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  in_item_t    in_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_item_t   out_data_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  chroma_vertical_shift_lowpass u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // Clock with a 12 ns period.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Stimulus waiting to be driven and rows the block still owes us.
  in_item_t  pixel_queue[$];
  out_item_t rows_due[$];

  // Shadow of the line window, counters and register values.
  logic [15:0] win_words[WIN_LINES][DEF_MAX_WIDTH];
  int unsigned row_cnt = 0;
  int unsigned col_cnt = 0;
  int          shift_cfg = 0;
  bit          lp_cfg = 1'b0;
  int unsigned width_cfg = 720;
  int unsigned height_cfg = 480;

  int unsigned cycles = 0;
  int unsigned errors = 0;
  int unsigned beats_in = 0;
  int unsigned beats_out = 0;
  int unsigned settings_run = 0;
  bit          in_took = 1'b0;
  bit          quiet = 1'b0;
  int unsigned in_gap = 0;
  int unsigned out_gap = 0;

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycles, msg);
    errors++;
  endtask

  function automatic int chroma_of(int row, int col);
    return int'(win_words[row % WIN_LINES][col][15:8]);
  endfunction

  // Fractional vertical shift of one chroma sample.
  function automatic int shifted_chroma(int k, int col);
    int d;
    int f;
    int m;
    if (shift_cfg > 0) begin
      d = shift_cfg / 8;
      f = shift_cfg % 8;
      if (k + d + 1 < int'(height_cfg))
        return (chroma_of(k + d, col) * (8 - f) + chroma_of(k + d + 1, col) * f) >> 3;
    end else if (shift_cfg < 0) begin
      m = -shift_cfg;
      d = m / 8;
      f = m % 8;
      if (k > d)
        return (chroma_of(k - d - 1, col) * f + chroma_of(k - d, col) * (8 - f)) >> 3;
    end
    return chroma_of(k, col);
  endfunction

  // Shifted chroma, then the 1-2-1 filter on inner rows when it is on.
  function automatic int filtered_chroma(int k, int col);
    if (lp_cfg && k >= 1 && k <= int'(height_cfg) - 2)
      return (shifted_chroma(k - 1, col) + 2 * shifted_chroma(k, col) +
              shifted_chroma(k + 1, col)) >> 2;
    return shifted_chroma(k, col);
  endfunction

  // Store one accepted pixel and queue the rows it releases.
  task automatic predict_rows(input in_item_t px);
    int unsigned r;
    int unsigned c;
    int          look;
    int          first;
    int          last;
    out_item_t   o;
    r = row_cnt;
    c = col_cnt;
    if (px.frame_start) begin
      r = 0;
      c = 0;
    end
    if (c >= width_cfg) begin
      c = 0;
      r++;
    end
    if (r >= height_cfg) r = 0;
    win_words[r % WIN_LINES][c] = {px.chroma_in, px.luma_in};
    look = (shift_cfg > 0 ? shift_cfg / 8 + 1 : 0) + int'(lp_cfg);
    if (int'(r) == int'(height_cfg) - 1) begin
      first = int'(r) >= look ? int'(r) - look : 0;
      last = int'(r);
    end else if (int'(r) >= look) begin
      first = int'(r) - look;
      last = first;
    end else begin
      first = 0;
      last = -1;
    end
    for (int k = first; k <= last; k++) begin
      o.luma_out = win_words[k % WIN_LINES][c][7:0];
      o.chroma_out = 8'(filtered_chroma(k, int'(c)));
      o.out_row = 10'(k);
      o.run_last = (k == last);
      rows_due.push_back(o);
    end
    c++;
    if (c >= width_cfg) begin
      c = 0;
      r++;
      if (r >= height_cfg) r = 0;
    end
    row_cnt = r;
    col_cnt = c;
  endtask

  // Input driver: one beat per handshake, random idle bursts.
  always @(negedge clk_i) begin : drive_pixels
    logic     nv;
    in_item_t nd;
    if (rst_ni) begin
      nv = in_valid_i;
      nd = in_data_i;
      if (in_took) nv = 1'b0;
      if (!nv) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
          in_gap = $urandom_range(1, 13);
        end else if (pixel_queue.size() > 0) begin
          nd = pixel_queue.pop_front();
          nv = 1'b1;
        end
      end
      in_valid_i <= nv;
      in_data_i <= nd;
    end
  end

  // Output stall in random bursts.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_gap > 0) begin
        out_gap--;
        out_stall_i <= (out_gap != 0);
      end else if (!quiet && $urandom_range(0, 11) == 0) begin
        out_gap = $urandom_range(1, 13);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Monitor: predict on input beats, check output beats.
  always @(posedge clk_i) begin : watch_beats
    out_item_t e;
    cycles++;
    in_took <= in_valid_i && !in_stall_o;
    if (in_valid_i && !in_stall_o) begin
      predict_rows(in_data_i);
      beats_in++;
    end
    if (out_valid_o && !out_stall_i) begin
      beats_out++;
      if (rows_due.size() == 0) begin
        report_mismatch("output beat with nothing expected");
      end else begin
        e = rows_due.pop_front();
        if (out_data_o.luma_out !== e.luma_out)
          report_mismatch($sformatf("luma_out %0h, expected %0h",
                                    out_data_o.luma_out, e.luma_out));
        if (out_data_o.chroma_out !== e.chroma_out)
          report_mismatch($sformatf("chroma_out %0h, expected %0h (row %0d)",
                                    out_data_o.chroma_out, e.chroma_out, e.out_row));
        if (out_data_o.out_row !== e.out_row)
          report_mismatch($sformatf("out_row %0d, expected %0d",
                                    out_data_o.out_row, e.out_row));
        if (out_data_o.run_last !== e.run_last)
          report_mismatch($sformatf("run_last %0b, expected %0b",
                                    out_data_o.run_last, e.run_last));
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout with %0d rows outstanding", rows_due.size());
      $display("[chroma_vertical_shift_lowpass] ERROR");
      $finish;
    end
  end

  // APB write: setup phase, then access phase.
  task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
    @(negedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Wait until all beats are in and out, then let the pipeline settle.
  task automatic wait_idle();
    while (pixel_queue.size() > 0 || in_valid_i || rows_due.size() > 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic apply_settings(input int sh, input bit lp, input int w, input int h);
    wait_idle();
    reg_write(REG_VERT_SHIFT, 32'(sh) & 32'h7f);
    reg_write(REG_LOW_PASS, {31'b0, lp});
    reg_write(REG_WIDTH, 32'(w));
    reg_write(REG_HEIGHT, 32'(h));
    shift_cfg = sh;
    lp_cfg = lp;
    width_cfg = w;
    height_cfg = h;
    settings_run++;
  endtask

  // One whole frame of random content; a frame may be cut short first.
  task automatic queue_frame(input bit allow_cut);
    in_item_t    px;
    int unsigned n;
    int unsigned cut;
    bit          was_cut;
    n = width_cfg * height_cfg;
    was_cut = 1'b0;
    if (allow_cut && $urandom_range(0, 9) == 0) begin
      was_cut = 1'b1;
      cut = $urandom_range(1, n - 1);
      for (int unsigned i = 0; i < cut; i++) begin
        px.luma_in = 8'($urandom);
        px.chroma_in = 8'($urandom);
        px.frame_start = (i == 0);
        pixel_queue.push_back(px);
      end
    end
    for (int unsigned i = 0; i < n; i++) begin
      px.luma_in = 8'($urandom);
      px.chroma_in = 8'($urandom);
      // A frame after a cut one always restarts; otherwise the wrap may do it.
      px.frame_start = (i == 0) && (was_cut || $urandom_range(0, 3) != 0);
      pixel_queue.push_back(px);
    end
  endtask

  initial begin : stimulus
    in_item_t    px;
    int unsigned sent;
    int          sh;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: smallest frame with extreme pixel values, strongest up-shift.
    apply_settings(32, 1'b1, 4, 3);
    for (int i = 0; i < 12; i++) begin
      px.luma_in = (i % 2) ? 8'hff : 8'h00;
      px.chroma_in = (i % 3 == 0) ? 8'hff : 8'h00;
      px.frame_start = (i == 0);
      pixel_queue.push_back(px);
    end
    // Strongest down-shift without the filter.
    apply_settings(-32, 1'b0, 4, 3);
    for (int i = 0; i < 12; i++) begin
      px.luma_in = 8'(i * 23);
      px.chroma_in = (i % 2) ? 8'h00 : 8'hff;
      px.frame_start = (i == 0);
      pixel_queue.push_back(px);
    end

    // A wider frame and a taller frame, once each.
    apply_settings(13, 1'b1, 16, 3);
    queue_frame(1'b0);
    apply_settings(-19, 1'b1, 4, 16);
    queue_frame(1'b0);

    // Random settings on small frames.
    sent = 0;
    while (sent < 220) begin
      case ($urandom_range(0, 4))
        0: sh = 32;
        1: sh = -32;
        2: sh = 0;
        default: sh = $urandom_range(0, 64) - 32;
      endcase
      apply_settings(sh, 1'($urandom), $urandom_range(4, 9), $urandom_range(3, 12));
      if (sent > 170) quiet = 1'b1;
      repeat ($urandom_range(1, 2)) begin
        queue_frame(1'b1);
        sent += width_cfg * height_cfg;
      end
    end

    wait_idle();
    $display("%0d input beats and %0d output beats checked over %0d register settings,",
             beats_in, beats_out, settings_run);
    $display("shifts from -32 to 32, filter on and off, frames up to 16 wide or high.");
    if (errors == 0 && rows_due.size() == 0) begin
      $display("[chroma_vertical_shift_lowpass] OK");
    end else begin
      $display("%0d mismatches, %0d rows never seen", errors, rows_due.size());
      $display("[chroma_vertical_shift_lowpass] ERROR");
    end
    $finish;
  end

endmodule

[chroma_vertical_shift_lowpass.f]
rtl/cvsl_pkg.sv
rtl/cvsl_front.sv
rtl/cvsl_queue.sv
rtl/cvsl_back.sv
rtl/chroma_vertical_shift_lowpass.sv
dv/testbench.sv
